// ----- rtl/hsvd_pkg.sv -----
// Shared constants and register codes for the half-size video downscaler.
// Used by the stream interfaces, the top level and the line buffer RAM users.
package hsvd_pkg;

    localparam int PIXEL_W        = 8;
    localparam int MAX_LINE_WIDTH = 2048;
    localparam int MAX_LINES      = 2048;
    localparam int MIN_LINE_WIDTH = 4;
    localparam int MIN_LINES      = 2;

    // Size registers and position counters.
    localparam int DIM_W   = 12;
    localparam int COUNT_W = 11;

    // Line buffers hold one sample per output column.
    localparam int HALF_DEPTH  = MAX_LINE_WIDTH / 2;
    localparam int HALF_ADDR_W = $clog2(HALF_DEPTH);

    // Configuration port.
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = DIM_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LINES   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_H_FILTER_MODE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_FILTER_MODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_MODE    = 3'd4;

    localparam logic [MODE_W-1:0] H_DECIMATE = 2'd0;
    localparam logic [MODE_W-1:0] H_FILTER   = 2'd1;
    localparam logic [MODE_W-1:0] H_AVERAGE  = 2'd2;

    localparam logic [MODE_W-1:0] V_DROP    = 2'd0;
    localparam logic [MODE_W-1:0] V_FILTER  = 2'd1;
    localparam logic [MODE_W-1:0] V_AVERAGE = 2'd2;

    localparam logic [MODE_W-1:0] FIELD_ALL  = 2'd0;
    localparam logic [MODE_W-1:0] FIELD_EVEN = 2'd1;
    localparam logic [MODE_W-1:0] FIELD_ODD  = 2'd2;

    localparam logic [DIM_W-1:0]  RESET_LINE_WIDTH  = 12'd720;
    localparam logic [DIM_W-1:0]  RESET_FRAME_LINES = 12'd576;
    localparam logic [MODE_W-1:0] RESET_H_MODE      = H_FILTER;
    localparam logic [MODE_W-1:0] RESET_V_MODE      = V_FILTER;
    localparam logic [MODE_W-1:0] RESET_FIELD_MODE  = FIELD_ALL;

endpackage

// ----- rtl/hsvd_in_if.sv -----
// Source pixel stream channel: valid/ready handshake with one sample per request.
// Depends on hsvd_pkg for the sample width.
interface hsvd_in_if;
    logic                         valid;
    logic                         ready;
    logic [hsvd_pkg::PIXEL_W-1:0] pixel;
    logic                         start_of_frame;

    modport source (output valid, output pixel, output start_of_frame, input ready);
    modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

// ----- rtl/hsvd_out_if.sv -----
// Downscaled pixel stream channel: valid/ready handshake with line and frame marks.
// Depends on hsvd_pkg for the sample width.
interface hsvd_out_if;
    logic                         valid;
    logic                         ready;
    logic [hsvd_pkg::PIXEL_W-1:0] out_pixel;
    logic                         last_of_line;
    logic                         last_of_frame;

    modport source (output valid, output out_pixel, output last_of_line,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input last_of_line,
                    input last_of_frame, output ready);
endinterface

// ----- rtl/hsvd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module hsvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/half_size_video_downscaler_top.sv -----
// Half-size video downscaler: horizontal and vertical 2:1 reduction of one plane.
// A request that completes a result passes through stage one and then the output register.
// Throughput: one request per cycle while the output is not held off; the line buffer read in
// stage one and the output register set the two-stage depth.
// Reset clears counters, sample holds, pipeline valids and configuration;
// line buffer contents are left as they are and need no clearing pass.
module half_size_video_downscaler_top (
    input  logic                             clk,
    input  logic                             rst_n,
    hsvd_in_if.sink                          video,
    hsvd_out_if.source                       scaled,
    input  logic                             cfg_we,
    input  logic [hsvd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hsvd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    typedef enum logic [1:0] {
        OP_STORE,
        OP_FILTER,
        OP_AVERAGE,
        OP_PASS
    } op_t;

    localparam int PW = hsvd_pkg::PIXEL_W;
    localparam int DW = hsvd_pkg::DIM_W;
    localparam int CW = hsvd_pkg::COUNT_W;
    localparam int AW = hsvd_pkg::HALF_ADDR_W;
    localparam int MW = hsvd_pkg::MODE_W;

    // Configuration registers.
    logic [DW-1:0] line_width_reg;
    logic [DW-1:0] frame_lines_reg;
    logic [MW-1:0] h_mode_reg;
    logic [MW-1:0] v_mode_reg;
    logic [MW-1:0] field_mode_reg;

    // Position and horizontal history.
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [PW-1:0] even_hold_reg, even_hold_next;
    logic [PW-1:0] odd_hold_reg, odd_hold_next;

    // Stage one: horizontal result waiting for line buffer data.
    logic          s1_valid_reg, s1_valid_next;
    op_t           s1_op_reg, s1_op_next;
    logic [AW-1:0] s1_addr_reg, s1_addr_next;
    logic [PW-1:0] s1_hv_reg, s1_hv_next;
    logic          s1_top_reg, s1_top_next;
    logic          s1_lol_reg, s1_lol_next;
    logic          s1_lof_reg, s1_lof_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_pixel_reg, out_pixel_next;
    logic          out_lol_reg, out_lol_next;
    logic          out_lof_reg, out_lof_next;

    logic          accept;
    logic          advance;

    logic [DW-1:0] width_even, height_even;
    logic [DW-1:0] act_width, act_lines;
    logic [CW-1:0] half_width;
    logic [CW-1:0] c, r;
    logic [CW-1:0] c_half;
    logic [CW-1:0] hi;
    logic [PW-1:0] hv;
    logic          have;
    logic [9:0]    sum3;
    logic [9:0]    sum_edge;
    logic [8:0]    sum_pair;
    logic          step2;
    logic          keep;
    logic [CW-1:0] fr;
    logic [CW-2:0] j;
    logic          p;
    logic [CW-1:0] out_rows;
    logic          in_range;
    logic          lol, lof;

    logic [PW-1:0] recent_rdata, older_rdata;
    logic          recent_we, older_we;
    logic [PW-1:0] above;
    logic [9:0]    vsum3;
    logic [8:0]    vsum_pair;
    logic [PW-1:0] ov;

    // Effective sizes: forced even, then clamped to the supported range.
    always_comb
    begin
        width_even  = {line_width_reg[DW-1:1], 1'b0};
        height_even = {frame_lines_reg[DW-1:1], 1'b0};
        act_width   = width_even;
        act_lines   = height_even;
        if (width_even < DW'(hsvd_pkg::MIN_LINE_WIDTH))
        begin
            act_width = DW'(hsvd_pkg::MIN_LINE_WIDTH);
        end
        else if (width_even > DW'(hsvd_pkg::MAX_LINE_WIDTH))
        begin
            act_width = DW'(hsvd_pkg::MAX_LINE_WIDTH);
        end
        if (height_even < DW'(hsvd_pkg::MIN_LINES))
        begin
            act_lines = DW'(hsvd_pkg::MIN_LINES);
        end
        else if (height_even > DW'(hsvd_pkg::MAX_LINES))
        begin
            act_lines = DW'(hsvd_pkg::MAX_LINES);
        end
    end

    assign half_width = act_width[DW-1:1];

    assign advance      = !out_valid_reg || scaled.ready;
    assign video.ready  = !s1_valid_reg || advance;
    assign accept       = video.valid && video.ready;

    assign c      = video.start_of_frame ? '0 : col_reg;
    assign r      = video.start_of_frame ? '0 : row_reg;
    assign c_half = {1'b0, c[CW-1:1]};

    assign sum3     = 10'(even_hold_reg) + {1'b0, odd_hold_reg, 1'b0} + 10'(video.pixel);
    assign sum_edge = 10'(even_hold_reg) + {1'b0, video.pixel, 1'b0} + 10'(video.pixel);
    assign sum_pair = 9'(even_hold_reg) + 9'(video.pixel);

    // Horizontal stage.
    always_comb
    begin
        hi   = '0;
        hv   = '0;
        have = 1'b0;
        case (h_mode_reg)
            hsvd_pkg::H_FILTER:
            begin
                if (!c[0] && (c != '0))
                begin
                    hi   = c_half - CW'(1);
                    hv   = sum3[9:2];
                    have = 1'b1;
                end
                else if ({1'b0, c} == act_width - DW'(1))
                begin
                    hi   = c_half;
                    hv   = sum_edge[9:2];
                    have = 1'b1;
                end
            end
            hsvd_pkg::H_AVERAGE:
            begin
                if (c[0])
                begin
                    hi   = c_half;
                    hv   = sum_pair[8:1];
                    have = 1'b1;
                end
            end
            default:
            begin
                if (!c[0])
                begin
                    hi   = c_half;
                    hv   = video.pixel;
                    have = 1'b1;
                end
            end
        endcase
    end

    // Field selection and vertical position.
    assign step2    = (field_mode_reg == hsvd_pkg::FIELD_EVEN)
                   || (field_mode_reg == hsvd_pkg::FIELD_ODD);
    assign keep     = !step2 || (r[0] == (field_mode_reg == hsvd_pkg::FIELD_ODD));
    assign fr       = step2 ? {1'b0, r[CW-1:1]} : r;
    assign j        = fr[CW-1:1];
    assign p        = fr[0];
    assign out_rows = step2 ? {1'b0, act_lines[DW-1:2]} : act_lines[DW-1:1];
    assign in_range = have && (hi < half_width) && keep && ({1'b0, j} < out_rows);
    assign lol      = (hi == half_width - CW'(1));
    assign lof      = lol && ({1'b0, j} == out_rows - CW'(1));

    // First stage: position update and the decision what the second stage does.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        even_hold_next = even_hold_reg;
        odd_hold_next  = odd_hold_reg;
        s1_valid_next  = s1_valid_reg;
        s1_op_next     = s1_op_reg;
        s1_addr_next   = s1_addr_reg;
        s1_hv_next     = s1_hv_reg;
        s1_top_next    = s1_top_reg;
        s1_lol_next    = s1_lol_reg;
        s1_lof_next    = s1_lof_reg;
        if (accept)
        begin
            if (c[0])
            begin
                odd_hold_next = video.pixel;
            end
            else
            begin
                even_hold_next = video.pixel;
            end
            if ({1'b0, c} >= act_width - DW'(1))
            begin
                col_next = '0;
                row_next = ({1'b0, r} >= act_lines - DW'(1)) ? '0 : r + CW'(1);
            end
            else
            begin
                col_next = c + CW'(1);
                row_next = r;
            end

            s1_valid_next = 1'b0;
            s1_op_next    = OP_PASS;
            if (in_range)
            begin
                case (v_mode_reg)
                    hsvd_pkg::V_FILTER:
                    begin
                        s1_valid_next = 1'b1;
                        s1_op_next    = p ? OP_FILTER : OP_STORE;
                    end
                    hsvd_pkg::V_AVERAGE:
                    begin
                        s1_valid_next = 1'b1;
                        s1_op_next    = p ? OP_AVERAGE : OP_STORE;
                    end
                    default:
                    begin
                        s1_valid_next = !p;
                        s1_op_next    = OP_PASS;
                    end
                endcase
            end
            s1_addr_next = hi[AW-1:0];
            s1_hv_next   = hv;
            s1_top_next  = (j == '0);
            s1_lol_next  = lol;
            s1_lof_next  = lof;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Line buffers: read while a request is taken, written when stage one retires.
    assign recent_we = s1_valid_reg && advance && (s1_op_reg == OP_STORE);
    assign older_we  = s1_valid_reg && advance && (s1_op_reg == OP_FILTER);

    hsvd_ram #(
        .WIDTH (PW),
        .DEPTH (hsvd_pkg::HALF_DEPTH)
    ) u_recent_ram (
        .clk   (clk),
        .we    (recent_we),
        .waddr (s1_addr_reg),
        .wdata (s1_hv_reg),
        .re    (accept),
        .raddr (hi[AW-1:0]),
        .rdata (recent_rdata)
    );

    hsvd_ram #(
        .WIDTH (PW),
        .DEPTH (hsvd_pkg::HALF_DEPTH)
    ) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (s1_addr_reg),
        .wdata (s1_hv_reg),
        .re    (accept),
        .raddr (hi[AW-1:0]),
        .rdata (older_rdata)
    );

    // Second stage: vertical filter, pair average or pass-through. On the first output row the middle row
    // stands in for the row above.
    assign above     = s1_top_reg ? recent_rdata : older_rdata;
    assign vsum3     = 10'(above) + {1'b0, recent_rdata, 1'b0} + 10'(s1_hv_reg);
    assign vsum_pair = 9'(recent_rdata) + 9'(s1_hv_reg);

    always_comb
    begin
        case (s1_op_reg)
            OP_FILTER:  ov = vsum3[9:2];
            OP_AVERAGE: ov = vsum_pair[8:1];
            default:    ov = s1_hv_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        out_lol_next   = out_lol_reg;
        out_lof_next   = out_lof_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg && (s1_op_reg != OP_STORE);
            out_pixel_next = ov;
            out_lol_next   = s1_lol_reg;
            out_lof_next   = s1_lof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= hsvd_pkg::RESET_LINE_WIDTH;
            frame_lines_reg <= hsvd_pkg::RESET_FRAME_LINES;
            h_mode_reg      <= hsvd_pkg::RESET_H_MODE;
            v_mode_reg      <= hsvd_pkg::RESET_V_MODE;
            field_mode_reg  <= hsvd_pkg::RESET_FIELD_MODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsvd_pkg::CFG_LINE_WIDTH:    line_width_reg  <= cfg_wdata;
                hsvd_pkg::CFG_FRAME_LINES:   frame_lines_reg <= cfg_wdata;
                hsvd_pkg::CFG_H_FILTER_MODE: h_mode_reg      <= cfg_wdata[MW-1:0];
                hsvd_pkg::CFG_V_FILTER_MODE: v_mode_reg      <= cfg_wdata[MW-1:0];
                hsvd_pkg::CFG_FIELD_MODE:    field_mode_reg  <= cfg_wdata[MW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            even_hold_reg <= '0;
            odd_hold_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            even_hold_reg <= even_hold_next;
            odd_hold_reg  <= odd_hold_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg     <= s1_op_next;
        s1_addr_reg   <= s1_addr_next;
        s1_hv_reg     <= s1_hv_next;
        s1_top_reg    <= s1_top_next;
        s1_lol_reg    <= s1_lol_next;
        s1_lof_reg    <= s1_lof_next;
        out_pixel_reg <= out_pixel_next;
        out_lol_reg   <= out_lol_next;
        out_lof_reg   <= out_lof_next;
    end

    assign scaled.valid         = out_valid_reg;
    assign scaled.out_pixel     = out_pixel_reg;
    assign scaled.last_of_line  = out_lol_reg;
    assign scaled.last_of_frame = out_lof_reg;

endmodule

// ----- rtl/hsvd_checker.sv -----
// Port-level checks for the half-size video downscaler, attached by bind.
// Depends on hsvd_pkg and the top level's stream interfaces.
module hsvd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [hsvd_pkg::PIXEL_W-1:0] out_pixel,
    input logic                         last_of_line,
    input logic                         last_of_frame
);

    // A stalled result keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel)
            && $stable(last_of_line) && $stable(last_of_frame))
    else $error("stalled result changed or dropped");

    // The end of a frame is always also the end of a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> last_of_line)
    else $error("frame end without line end");

    // An empty output register never holds back the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

    // A new result follows a request that was taken and passed through stage one and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching request");

endmodule

bind half_size_video_downscaler_top hsvd_checker u_hsvd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (video.valid),
    .in_ready      (video.ready),
    .out_valid     (scaled.valid),
    .out_ready     (scaled.ready),
    .out_pixel     (scaled.out_pixel),
    .last_of_line  (scaled.last_of_line),
    .last_of_frame (scaled.last_of_frame)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the half-size video downscaler: pixel frames under many size,
// filter and field settings, each downscaled sample compared with a predicted one.
// Depends on hsvd_pkg, hsvd_in_if, hsvd_out_if and half_size_video_downscaler_top.
module tb;

    localparam int PW            = hsvd_pkg::PIXEL_W;
    localparam int DW            = hsvd_pkg::DIM_W;
    localparam int MW            = hsvd_pkg::MODE_W;
    localparam int CIW           = hsvd_pkg::CFG_INDEX_W;
    localparam int CDW           = hsvd_pkg::CFG_DATA_W;
    localparam int CLK_HALF      = 2;
    localparam int SETTLE_CYC    = 8;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 88;
    localparam int PRIME_WIDTH   = 32;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [PW-1:0] value;
        logic          line_end;
        logic          frame_end;
    } scaled_sample_t;

    class downscale_scoreboard;
        logic [DW-1:0]  line_width;
        logic [DW-1:0]  frame_lines;
        logic [MW-1:0]  h_mode;
        logic [MW-1:0]  v_mode;
        logic [MW-1:0]  field_sel;
        int unsigned    col;
        int unsigned    row;
        int unsigned    even_hold;
        int unsigned    odd_hold;
        int unsigned    upper_row [hsvd_pkg::HALF_DEPTH];
        int unsigned    held_row [hsvd_pkg::HALF_DEPTH];
        scaled_sample_t awaited [$];
        int             mismatches;

        function new();
            line_width  = hsvd_pkg::RESET_LINE_WIDTH;
            frame_lines = hsvd_pkg::RESET_FRAME_LINES;
            h_mode      = hsvd_pkg::RESET_H_MODE;
            v_mode      = hsvd_pkg::RESET_V_MODE;
            field_sel   = hsvd_pkg::RESET_FIELD_MODE;
            col         = 0;
            row         = 0;
            even_hold   = 0;
            odd_hold    = 0;
            mismatches  = 0;
            foreach (upper_row[i])
            begin
                upper_row[i] = 0;
                held_row[i]  = 0;
            end
        endfunction

        function void set_reg(logic [CIW-1:0] reg_index, logic [CDW-1:0] data);
            case (reg_index)
                hsvd_pkg::CFG_LINE_WIDTH:    line_width  = data;
                hsvd_pkg::CFG_FRAME_LINES:   frame_lines = data;
                hsvd_pkg::CFG_H_FILTER_MODE: h_mode      = data[MW-1:0];
                hsvd_pkg::CFG_V_FILTER_MODE: v_mode      = data[MW-1:0];
                hsvd_pkg::CFG_FIELD_MODE:    field_sel   = data[MW-1:0];
                default: ;
            endcase
        endfunction

        // Sizes lose bit 0 and then saturate to the supported range.
        function int unsigned clamp_size(logic [DW-1:0] raw, int unsigned lo,
                                         int unsigned hi);
            int unsigned sz;
            sz = 32'({raw[DW-1:1], 1'b0});
            if (sz < lo)
                sz = lo;
            if (sz > hi)
                sz = hi;
            return sz;
        endfunction

        function void note_request(logic [PW-1:0] pixel, logic start_flag);
            int unsigned w, h, c, r, p, hi, hv, ov, stride, fr, pair, out_rows, mid, above;
            bit have, emit, keep;
            scaled_sample_t sample;
            w = clamp_size(line_width, hsvd_pkg::MIN_LINE_WIDTH, hsvd_pkg::MAX_LINE_WIDTH);
            h = clamp_size(frame_lines, hsvd_pkg::MIN_LINES, hsvd_pkg::MAX_LINES);
            p = 32'(pixel);
            if (start_flag)
            begin
                col = 0;
                row = 0;
            end
            c    = col;
            r    = row;
            hi   = 0;
            hv   = 0;
            ov   = 0;
            have = 1'b0;
            emit = 1'b0;

            case (h_mode)
                hsvd_pkg::H_FILTER:
                begin
                    if (c % 2 == 0 && c >= 2)
                    begin
                        hi   = c / 2 - 1;
                        hv   = (even_hold + 2 * odd_hold + p) >> 2;
                        have = 1'b1;
                    end
                    else if (c == w - 1)
                    begin
                        // Right edge: the last pixel also stands in for its missing neighbor.
                        hi   = c / 2;
                        hv   = (even_hold + 3 * p) >> 2;
                        have = 1'b1;
                    end
                end
                hsvd_pkg::H_AVERAGE:
                begin
                    if (c % 2 == 1)
                    begin
                        hi   = c / 2;
                        hv   = (even_hold + p) >> 1;
                        have = 1'b1;
                    end
                end
                default:
                begin
                    if (c % 2 == 0)
                    begin
                        hi   = c / 2;
                        hv   = p;
                        have = 1'b1;
                    end
                end
            endcase
            if (c % 2 == 1)
                odd_hold = p;
            else
                even_hold = p;
            if (hi >= w / 2)
                have = 1'b0;

            // Field modes keep every other source line and then pair what is left.
            stride   = (field_sel == hsvd_pkg::FIELD_EVEN || field_sel == hsvd_pkg::FIELD_ODD)
                       ? 2 : 1;
            keep     = (stride == 1)
                       || ((r % 2) == ((field_sel == hsvd_pkg::FIELD_ODD) ? 1 : 0));
            fr       = r / stride;
            pair     = fr / 2;
            out_rows = h / (2 * stride);

            if (have && keep && pair < out_rows)
            begin
                case (v_mode)
                    hsvd_pkg::V_FILTER:
                    begin
                        if (fr % 2 == 0)
                            held_row[hi] = hv;
                        else
                        begin
                            mid   = held_row[hi];
                            above = (pair == 0) ? mid : upper_row[hi];
                            ov    = (above + 2 * mid + hv) >> 2;
                            upper_row[hi] = hv;
                            emit  = 1'b1;
                        end
                    end
                    hsvd_pkg::V_AVERAGE:
                    begin
                        if (fr % 2 == 0)
                            held_row[hi] = hv;
                        else
                        begin
                            ov   = (held_row[hi] + hv) >> 1;
                            emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (fr % 2 == 0)
                        begin
                            ov   = hv;
                            emit = 1'b1;
                        end
                    end
                endcase
            end

            if (c >= w - 1)
            begin
                col = 0;
                row = (r >= h - 1) ? 0 : r + 1;
            end
            else
                col = c + 1;

            if (emit)
            begin
                sample.value     = ov[PW-1:0];
                sample.line_end  = (hi == w / 2 - 1);
                sample.frame_end = sample.line_end && (pair == out_rows - 1);
                awaited.push_back(sample);
            end
        endfunction

        function void check_result(scaled_sample_t got);
            scaled_sample_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected scaled sample pixel %0d lol %b lof %b",
                             $time, got.value, got.line_end, got.frame_end);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.value !== want.value || got.line_end !== want.line_end ||
                    got.frame_end !== want.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: scaled sample mismatch: expected %0d/%b/%b got %0d/%b/%b",
                                 $time, want.value, want.line_end, want.frame_end,
                                 got.value, got.line_end, got.frame_end);
                end
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic [CIW-1:0] cfg_index;
    logic [CDW-1:0] cfg_wdata;

    hsvd_in_if  video_if ();
    hsvd_out_if scaled_if ();

    downscale_scoreboard board = new();

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    bit long_hold_armed = 1'b0;
    bit long_hold_taken = 1'b0;

    half_size_video_downscaler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .video     (video_if),
        .scaled    (scaled_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : result_sink
        int hold_left;
        scaled_sample_t got;
        hold_left = 0;
        scaled_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (scaled_if.valid === 1'b1 && scaled_if.ready === 1'b1)
            begin
                got.value     = scaled_if.out_pixel;
                got.line_end  = scaled_if.last_of_line;
                got.frame_end = scaled_if.last_of_frame;
                board.check_result(got);
            end
            if (long_hold_armed && !long_hold_taken)
            begin
                hold_left       = LONG_HOLD;
                long_hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                scaled_if.ready <= 1'b0;
            end
            else
                scaled_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [PW-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PW'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [PW-1:0] pixel, input logic start_flag);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            video_if.valid <= 1'b0;
            @(posedge clk);
        end
        video_if.valid          <= 1'b1;
        video_if.pixel          <= pixel;
        video_if.start_of_frame <= start_flag;
        do
            @(posedge clk);
        while (video_if.ready !== 1'b1);
        board.note_request(pixel, start_flag);
    endtask

    // A request may leave no result behind, so the pipeline is given a settling wait
    // once the last awaited sample has come out.
    task automatic wait_for_results();
        video_if.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIW-1:0] reg_index,
                             input logic [CDW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_wdata <= data;
        @(posedge clk);
        board.set_reg(reg_index, data);
    endtask

    task automatic apply_setup(input logic [DW-1:0] width, input logic [DW-1:0] lines,
                               input logic [MW-1:0] hm, input logic [MW-1:0] vm,
                               input logic [MW-1:0] fm);
        logic [CDW-1:0] junk;
        junk = CDW'($urandom);
        wait_for_results();
        write_reg(hsvd_pkg::CFG_LINE_WIDTH, width);
        write_reg(hsvd_pkg::CFG_FRAME_LINES, lines);
        // Mode registers only look at their low bits; the rest carry noise.
        write_reg(hsvd_pkg::CFG_H_FILTER_MODE, {junk[CDW-1:MW], hm});
        write_reg(hsvd_pkg::CFG_V_FILTER_MODE, {junk[CDW-1:MW], vm});
        write_reg(hsvd_pkg::CFG_FIELD_MODE, {junk[CDW-1:MW], fm});
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int phase);
        logic [DW-1:0] width;
        logic [DW-1:0] lines;
        int unsigned w, h, frame_len, pos, sent, style, cut, pause_at;
        case ($urandom_range(0, 9))
            0:       width = DW'($urandom);
            1:       width = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'd2048;
            default: width = DW'($urandom_range(0, 25));
        endcase
        if ($urandom_range(0, 9) < 2)
            lines = DW'($urandom);
        else
            lines = DW'($urandom_range(0, 13));
        apply_setup(width, lines, MW'($urandom_range(0, 3)), MW'($urandom_range(0, 3)),
                    MW'($urandom_range(0, 3)));
        w         = board.clamp_size(width, hsvd_pkg::MIN_LINE_WIDTH,
                                     hsvd_pkg::MAX_LINE_WIDTH);
        h         = board.clamp_size(lines, hsvd_pkg::MIN_LINES, hsvd_pkg::MAX_LINES);
        frame_len = w * h;
        pause_at  = (phase == RANDOM_PHASES / 2) ? PHASE_ITEMS / 2 : PHASE_ITEMS + 1;
        sent      = 0;
        while (sent < PHASE_ITEMS)
        begin
            // Most frames are whole and open with a start-of-frame mark; some lean on
            // the counters wrapping, and some are cut short by an early restart.
            // The first request of a phase always starts a frame, so a new setup never
            // continues a frame begun under the old one.
            style = $urandom_range(0, 99);
            cut   = (style >= 85) ? $urandom_range(1, frame_len) : frame_len;
            for (pos = 0; pos < cut && sent < PHASE_ITEMS; pos++)
            begin
                send_pixel(pick_pixel(), pos == 0 && (style < 70 || sent == 0));
                sent++;
                if (sent == pause_at)
                    wait_for_results();
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int pos;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= '0;
        cfg_wdata               <= '0;
        video_if.valid          <= 1'b0;
        video_if.pixel          <= '0;
        video_if.start_of_frame <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 49;

        // A short two-line frame with both filters on. The second line makes one
        // result per two requests, which is where the output gets held off.
        apply_setup(DW'(PRIME_WIDTH), 12'd2, hsvd_pkg::H_FILTER, hsvd_pkg::V_FILTER,
                    hsvd_pkg::FIELD_ALL);
        for (pos = 0; pos < 2 * PRIME_WIDTH; pos++)
        begin
            if (pos == PRIME_WIDTH + 8)
                long_hold_armed = 1'b1;
            send_pixel(pick_pixel(), pos == 0);
        end

        // Odd and undersized sizes fall back to the smallest frame; full-scale input.
        apply_setup(12'd5, 12'd1, hsvd_pkg::H_FILTER, hsvd_pkg::V_AVERAGE,
                    hsvd_pkg::FIELD_ALL);
        for (pos = 0; pos < 8; pos++)
            send_pixel(8'hFF, pos == 0);

        apply_setup(12'd4, 12'd4, hsvd_pkg::H_AVERAGE, hsvd_pkg::V_FILTER,
                    hsvd_pkg::FIELD_ODD);
        for (pos = 0; pos < 16; pos++)
            send_pixel((pos % 3 == 0) ? 8'h00 : 8'hFF, pos == 0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 30;
            end
            else if (phase == 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(phase);
        end

        wait_for_results();
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
